>>> hw/rtl/rmez_pkg.sv
// Shared constants for the rotation-matrix to Z-Y-X Euler angle core.
// Arctangent table, gain compensation and angle constants used by all CORDIC parts.
// No dependencies.
package rmez_pkg;

  // Guard bits appended below each input sample
  localparam int GUARD_BITS = 16;
  // Extra headroom bits above the sample for CORDIC growth and pre-rotation
  localparam int HEAD_BITS  = 3;
  // Number of arctangent entries available
  localparam int TABLE_LEN  = 24;

  // atan(2^-i) in units where 2^32 is a full turn
  localparam logic [31:0] ATAN_TAB [0:TABLE_LEN-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Quarter-turn pre-rotation offsets
  localparam logic [31:0] Z_PLUS_HALF  = 32'h4000_0000;
  localparam logic [31:0] Z_MINUS_HALF = 32'hC000_0000;
  // Rounding offset when dropping the low 16 accumulator bits
  localparam logic [31:0] BAM_ROUND    = 32'h0000_8000;

  // Inverse CORDIC gain, Q0.15, and its shift
  localparam logic signed [15:0] INV_GAIN_Q15 = 16'sd19898;
  localparam int                 GAIN_SHIFT   = 15;

  // Pitch output limits (plus or minus a quarter turn)
  localparam logic signed [15:0] PITCH_MAX = 16'sd16384;
  localparam logic signed [15:0] PITCH_MIN = -16'sd16384;

endpackage

>>> hw/rtl/rmez_dly.sv
// Fixed-depth register delay line used to keep side data aligned with the CORDIC chains.
// Depends on nothing.
module rmez_dly #(
  parameter int W     = 16,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap [0:DEPTH-1];

  // shift line, one tap per cycle
  always_ff @(posedge clk) begin
    tap[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      tap[i] <= tap[i-1];
    end
  end

  assign q = tap[DEPTH-1];

endmodule

>>> hw/rtl/rmez_cell.sv
// One CORDIC vectoring micro-rotation with its output registers.
// Uses rmez_pkg for the arctangent table.
module rmez_cell #(
  parameter int W    = 35,
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  input  logic        [31:0]  z_in,
  output logic signed [W-1:0] x_out,
  output logic signed [W-1:0] y_out,
  output logic        [31:0]  z_out
);

  import rmez_pkg::*;

  logic signed [W-1:0] xs;
  logic signed [W-1:0] ys;
  logic signed [W-1:0] x_next;
  logic signed [W-1:0] y_next;
  logic        [31:0]  z_next;

  // rotate toward the x axis; arithmetic shifts round toward minus infinity
  always_comb begin
    xs = x_in >>> STEP;
    ys = y_in >>> STEP;
    if (!y_in[W-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ATAN_TAB[STEP];
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ATAN_TAB[STEP];
    end
  end

  always_ff @(posedge clk) begin
    x_out <= x_next;
    y_out <= y_next;
    z_out <= z_next;
  end

endmodule

>>> hw/rtl/rmez_vec.sv
// CORDIC vectoring pass: quarter-turn pre-rotation stage, then a chain of micro-rotation cells.
// Gives a 16-bit binary angle of (x, y) and the unscaled magnitude.
// Depends on rmez_pkg, rmez_cell and rmez_dly.
module rmez_vec #(
  parameter int W     = 35,
  parameter int STEPS = 16
) (
  input  logic                clk,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  output logic        [15:0]  ang,
  output logic signed [W-1:0] mag
);

  import rmez_pkg::*;

  logic signed [W-1:0] x_pre_next;
  logic signed [W-1:0] y_pre_next;
  logic        [31:0]  z_pre_next;
  logic signed [W-1:0] x_pre;
  logic signed [W-1:0] y_pre;
  logic        [31:0]  z_pre;
  logic                zero_next;
  logic                zero_pre;
  logic                zero_end;
  logic        [31:0]  z_end;
  logic        [31:0]  z_rnd;

  logic signed [W-1:0] xc [0:STEPS];
  logic signed [W-1:0] yc [0:STEPS];
  logic        [31:0]  zc [0:STEPS];

  // bring left half plane vectors into the right half plane
  always_comb begin
    zero_next = (x_in == '0) && (y_in == '0);
    if (x_in[W-1]) begin
      if (!y_in[W-1]) begin
        x_pre_next = y_in;
        y_pre_next = -x_in;
        z_pre_next = Z_PLUS_HALF;
      end else begin
        x_pre_next = -y_in;
        y_pre_next = x_in;
        z_pre_next = Z_MINUS_HALF;
      end
    end else begin
      x_pre_next = x_in;
      y_pre_next = y_in;
      z_pre_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    x_pre    <= x_pre_next;
    y_pre    <= y_pre_next;
    z_pre    <= z_pre_next;
    zero_pre <= zero_next;
  end

  assign xc[0] = x_pre;
  assign yc[0] = y_pre;
  assign zc[0] = z_pre;

  // micro-rotation chain
  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    rmez_cell #(
      .W    (W),
      .STEP (g)
    ) u_cell (
      .clk   (clk),
      .x_in  (xc[g]),
      .y_in  (yc[g]),
      .z_in  (zc[g]),
      .x_out (xc[g+1]),
      .y_out (yc[g+1]),
      .z_out (zc[g+1])
    );
  end

  // zero-vector flag rides alongside the chain
  rmez_dly #(
    .W     (1),
    .DEPTH (STEPS)
  ) u_zero_dly (
    .clk (clk),
    .d   (zero_pre),
    .q   (zero_end)
  );

  // atan2(0,0) is defined as zero; round to 16-bit binary angle
  always_comb begin
    z_end = zero_end ? '0 : zc[STEPS];
    z_rnd = z_end + BAM_ROUND;
  end

  assign ang = z_rnd[31:16];
  assign mag = xc[STEPS];

endmodule

>>> hw/rtl/rotation_matrix_to_euler_zyx_core.sv
// Z-Y-X Euler angles (yaw, pitch, roll) from five rotation-matrix entries by CORDIC.
// Path: yaw and roll passes, gain multiply, pitch pass, output registers; N = min(CORDIC_STEPS, 24) cells per pass.
// Throughput: one item per cycle; busy is always low, the roll pass and the pitch pass
// are separate cell chains so a new item enters every cycle.
// Results appear for one cycle with done high; the receiver cannot stall.
// Reset clears only the done strobe pipeline; the datapath carries no reset.
module rotation_matrix_to_euler_zyx_core #(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] r00,
  input  logic signed [SAMPLE_BITS-1:0] r10,
  input  logic signed [SAMPLE_BITS-1:0] r20,
  input  logic signed [SAMPLE_BITS-1:0] r21,
  input  logic signed [SAMPLE_BITS-1:0] r22,
  output logic                          done,
  output logic signed [15:0]            yaw,
  output logic signed [15:0]            pitch,
  output logic signed [15:0]            roll
);

  import rmez_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int W     = SAMPLE_BITS + GUARD_BITS + HEAD_BITS;
  localparam int PW    = W + 16;
  localparam int L1    = NSTEP + 1;
  localparam int LAT   = 2 * L1 + 2;

  logic signed [W-1:0]  r00_x;
  logic signed [W-1:0]  r10_x;
  logic signed [W-1:0]  r20_x;
  logic signed [W-1:0]  r21_x;
  logic signed [W-1:0]  r22_x;
  logic        [W-1:0]  r20_d;
  logic signed [W-1:0]  p_y;
  logic        [15:0]   yaw_ang;
  logic        [15:0]   roll_ang;
  logic        [15:0]   yaw_d;
  logic        [15:0]   roll_d;
  logic        [15:0]   pitch_ang;
  logic signed [W-1:0]  yaw_mag;
  logic signed [W-1:0]  roll_mag;
  logic signed [W-1:0]  pitch_mag;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_rnd;
  logic signed [W-1:0]  gain_mag;
  logic signed [15:0]   pitch_next;
  logic        [LAT-2:0] vld;

  assign busy = 1'b0;

  // sign-extend and append guard bits
  assign r00_x = {{HEAD_BITS{r00[SAMPLE_BITS-1]}}, r00, {GUARD_BITS{1'b0}}};
  assign r10_x = {{HEAD_BITS{r10[SAMPLE_BITS-1]}}, r10, {GUARD_BITS{1'b0}}};
  assign r20_x = {{HEAD_BITS{r20[SAMPLE_BITS-1]}}, r20, {GUARD_BITS{1'b0}}};
  assign r21_x = {{HEAD_BITS{r21[SAMPLE_BITS-1]}}, r21, {GUARD_BITS{1'b0}}};
  assign r22_x = {{HEAD_BITS{r22[SAMPLE_BITS-1]}}, r22, {GUARD_BITS{1'b0}}};

  // yaw and roll passes run side by side
  rmez_vec #(.W(W), .STEPS(NSTEP)) u_yaw (
    .clk  (clk),
    .x_in (r00_x),
    .y_in (r10_x),
    .ang  (yaw_ang),
    .mag  (yaw_mag)
  );

  rmez_vec #(.W(W), .STEPS(NSTEP)) u_roll (
    .clk  (clk),
    .x_in (r22_x),
    .y_in (r21_x),
    .ang  (roll_ang),
    .mag  (roll_mag)
  );

  // r20 waits for the roll magnitude plus the gain stage
  rmez_dly #(.W(W), .DEPTH(L1 + 1)) u_r20_dly (
    .clk (clk),
    .d   (r20_x),
    .q   (r20_d)
  );

  // inverse gain scaling of the roll magnitude
  always_ff @(posedge clk) begin
    prod <= PW'(roll_mag) * PW'(INV_GAIN_Q15);
  end

  always_comb begin
    prod_rnd = prod + PW'(1 << (GAIN_SHIFT - 1));
    gain_mag = prod_rnd[W+GAIN_SHIFT-1:GAIN_SHIFT];
    p_y      = -$signed(r20_d);
  end

  // pitch pass
  rmez_vec #(.W(W), .STEPS(NSTEP)) u_pitch (
    .clk  (clk),
    .x_in (gain_mag),
    .y_in (p_y),
    .ang  (pitch_ang),
    .mag  (pitch_mag)
  );

  // yaw and roll wait for the pitch pass
  rmez_dly #(.W(16), .DEPTH(L1 + 1)) u_yaw_dly (
    .clk (clk),
    .d   (yaw_ang),
    .q   (yaw_d)
  );

  rmez_dly #(.W(16), .DEPTH(L1 + 1)) u_roll_dly (
    .clk (clk),
    .d   (roll_ang),
    .q   (roll_d)
  );

  // clamp pitch to a quarter turn
  always_comb begin
    if ($signed(pitch_ang) > PITCH_MAX) begin
      pitch_next = PITCH_MAX;
    end else if ($signed(pitch_ang) < PITCH_MIN) begin
      pitch_next = PITCH_MIN;
    end else begin
      pitch_next = $signed(pitch_ang);
    end
  end

  // output registers
  always_ff @(posedge clk) begin
    yaw   <= $signed(yaw_d);
    pitch <= pitch_next;
    roll  <= $signed(roll_d);
  end

  // strobe pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[LAT-3:0], start};
      done <= vld[LAT-2];
    end
  end

  // a result strobe always traces back to an accepted item
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("done without a matching start");

  // clamped pitch stays within a quarter turn
  a_pitch_rng: assert property (@(posedge clk) disable iff (rst)
    done |-> (pitch <= PITCH_MAX && pitch >= PITCH_MIN))
    else $error("pitch out of range");

  // zero roll vector yields zero roll
  a_roll_zero: assert property (@(posedge clk) disable iff (rst)
    (start && r21 == '0 && r22 == '0) |-> ##LAT (roll == '0))
    else $error("roll of zero vector not zero");

  // zero yaw vector yields zero yaw
  a_yaw_zero: assert property (@(posedge clk) disable iff (rst)
    (start && r00 == '0 && r10 == '0) |-> ##LAT (yaw == '0))
    else $error("yaw of zero vector not zero");

endmodule

>>> dv/rotation_matrix_to_euler_zyx_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for rotation_matrix_to_euler_zyx_core (yaw/pitch/roll by CORDIC).
// Depends on the core, which uses rmez_pkg; carries its own bit-exact CORDIC predictor.
module rotation_matrix_to_euler_zyx_core_tb;

  localparam int CORDIC_STEPS = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int PASSES       = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int LATENCY      = 2 * PASSES + 4;
  localparam int N_RANDOM     = 630;
  localparam int DRAIN_AT     = 450;
  localparam int CYCLE_LIMIT  = 200000;

  // atan(2^-i), 2^32 per full turn
  localparam logic [31:0] ATAN_STEP [0:23] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };
  localparam logic [31:0] QUARTER_POS = 32'h4000_0000;
  localparam logic [31:0] QUARTER_NEG = 32'hC000_0000;
  localparam longint      INV_GAIN    = 19898;
  localparam logic [15:0] PITCH_UP    = 16'h4000;
  localparam logic [15:0] PITCH_DOWN  = 16'hC000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] m00;
    logic signed [SAMPLE_BITS-1:0] m10;
    logic signed [SAMPLE_BITS-1:0] m20;
    logic signed [SAMPLE_BITS-1:0] m21;
    logic signed [SAMPLE_BITS-1:0] m22;
  } matrix_t;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [SAMPLE_BITS-1:0] r00 = '0;
  logic signed [SAMPLE_BITS-1:0] r10 = '0;
  logic signed [SAMPLE_BITS-1:0] r20 = '0;
  logic signed [SAMPLE_BITS-1:0] r21 = '0;
  logic signed [SAMPLE_BITS-1:0] r22 = '0;
  logic done;
  logic signed [15:0] yaw, pitch, roll;

  matrix_t pending_mats[$];
  angles_t expected_angles[$];
  int      n_sent = 0;
  int      n_checked = 0;
  int      n_fail = 0;
  int      cycles = 0;
  bit      drained = 1'b0;

  rotation_matrix_to_euler_zyx_core #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .r00  (r00),
    .r10  (r10),
    .r20  (r20),
    .r21  (r21),
    .r22  (r22),
    .done (done),
    .yaw  (yaw),
    .pitch(pitch),
    .roll (roll)
  );

  always #1 clk = ~clk;

  // CORDIC vectoring: angle of (x, y) in 2^32 units, raw (unscaled) magnitude out
  function automatic logic [31:0] cordic_vector(input longint xi, input longint yi,
                                                output longint raw_mag);
    longint x, y, t, xs, ys;
    logic [31:0] z;
    x = xi;
    y = yi;
    z = '0;
    raw_mag = 0;
    if (x == 0 && y == 0) return '0;
    // left half plane: quarter-turn pre-rotation
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;  y = -t; z = QUARTER_POS;
      end else begin
        x = -y; y = t;  z = QUARTER_NEG;
      end
    end
    for (int i = 0; i < PASSES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_STEP[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_STEP[i];
      end
    end
    raw_mag = x;
    return z;
  endfunction

  function automatic logic [15:0] to_bam(input logic [31:0] z);
    logic [31:0] s;
    s = z + 32'h8000;
    return s[31:16];
  endfunction

  function automatic angles_t predict_angles(input matrix_t m);
    longint  a00, a10, a20, a21, a22, raw, mag, unused;
    logic [31:0] zy, zr, zp;
    logic [15:0] p;
    angles_t res;
    a00 = longint'(m.m00) <<< 16;
    a10 = longint'(m.m10) <<< 16;
    a20 = longint'(m.m20) <<< 16;
    a21 = longint'(m.m21) <<< 16;
    a22 = longint'(m.m22) <<< 16;
    zy  = cordic_vector(a00, a10, unused);
    zr  = cordic_vector(a22, a21, raw);
    mag = (raw * INV_GAIN + 16384) >>> 15;
    zp  = cordic_vector(mag, -a20, unused);
    p   = to_bam(zp);
    // pitch limited to a quarter turn either way
    if (p[15]) begin
      if (p < PITCH_DOWN) p = PITCH_DOWN;
    end else if (p > PITCH_UP) begin
      p = PITCH_UP;
    end
    res.yaw   = to_bam(zy);
    res.pitch = p;
    res.roll  = to_bam(zr);
    return res;
  endfunction

  function automatic matrix_t make_matrix(input int a, input int b, input int c,
                                          input int d, input int e);
    matrix_t m;
    m.m00 = a[SAMPLE_BITS-1:0];
    m.m10 = b[SAMPLE_BITS-1:0];
    m.m20 = c[SAMPLE_BITS-1:0];
    m.m21 = d[SAMPLE_BITS-1:0];
    m.m22 = e[SAMPLE_BITS-1:0];
    return m;
  endfunction

  function automatic int rand_signed(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // proper Z-Y-X rotation from random angles; occasionally pinned at gimbal lock
  function automatic matrix_t random_rotation();
    real pi_r, ya, pa, ra, cy, sy, cp, sp, cr, sr;
    pi_r = 3.14159265358979;
    ya = ($urandom_range(1000000) / 500000.0 - 1.0) * pi_r;
    ra = ($urandom_range(1000000) / 500000.0 - 1.0) * pi_r;
    pa = ($urandom_range(1000000) / 500000.0 - 1.0) * pi_r / 2.0;
    if ($urandom_range(19) == 0) pa = ($urandom_range(1) != 0) ? pi_r / 2.0 : -pi_r / 2.0;
    cy = $cos(ya); sy = $sin(ya);
    cp = $cos(pa); sp = $sin(pa);
    cr = $cos(ra); sr = $sin(ra);
    return make_matrix(int'(cy * cp * 16384.0), int'(sy * cp * 16384.0),
                       int'(-sp * 16384.0), int'(cp * sr * 16384.0),
                       int'(cp * cr * 16384.0));
  endfunction

  task automatic check_field(input string name, input logic signed [15:0] exp_v,
                             input logic signed [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // Driver: item accepted at an edge with start high and busy low
  always @(posedge clk) begin
    int idle_pct;
    matrix_t m;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_angles.push_back(predict_angles(make_matrix(r00, r10, r20, r21, r22)));
        n_sent++;
      end
      idle_pct = (n_sent >= 200 && n_sent < 350) ? 0 : 25;
      if (start && busy) begin
        // not taken yet: hold the item
      end else if (n_sent >= DRAIN_AT && !drained && expected_angles.size() != 0) begin
        start <= 1'b0;
      end else begin
        if (n_sent >= DRAIN_AT) drained = 1'b1;
        if (pending_mats.size() != 0 && $urandom_range(99) >= idle_pct) begin
          m = pending_mats.pop_front();
          r00   <= m.m00;
          r10   <= m.m10;
          r20   <= m.m20;
          r21   <= m.m21;
          r22   <= m.m22;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each done strobe against the oldest expectation
  always @(posedge clk) begin
    angles_t want;
    if (!rst && done) begin
      if (expected_angles.size() == 0) begin
        $error("result with no item pending: yaw %0d pitch %0d roll %0d", yaw, pitch, roll);
        n_fail++;
      end else begin
        want = expected_angles.pop_front();
        check_field("yaw", want.yaw, yaw);
        check_field("pitch", want.pitch, pitch);
        check_field("roll", want.roll, roll);
        n_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** rotation_matrix_to_euler_zyx_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int k;
    // directed: zero vectors, identity, half-turn wrap, quadrants, gimbal lock
    pending_mats.push_back(make_matrix(0, 0, 0, 0, 0));
    pending_mats.push_back(make_matrix(16384, 0, 0, 0, 16384));
    pending_mats.push_back(make_matrix(-16384, 0, 0, 0, -16384));
    pending_mats.push_back(make_matrix(-16384, -1, 0, -1, -16384));
    pending_mats.push_back(make_matrix(-16384, 16384, 0, 16384, -16384));
    pending_mats.push_back(make_matrix(-16384, -16384, 0, -16384, -16384));
    pending_mats.push_back(make_matrix(0, 16384, 0, 16384, 0));
    pending_mats.push_back(make_matrix(0, -16384, 0, -16384, 0));
    pending_mats.push_back(make_matrix(0, 0, -16384, 0, 0));
    pending_mats.push_back(make_matrix(0, 0, 16384, 0, 0));
    pending_mats.push_back(make_matrix(16384, 0, -16384, 1, 0));
    pending_mats.push_back(make_matrix(0, 0, 16383, 0, -1));
    pending_mats.push_back(make_matrix(16384, 16384, 16384, 16384, 16384));
    pending_mats.push_back(make_matrix(-16384, -16384, -16384, -16384, -16384));
    pending_mats.push_back(make_matrix(16384, -16384, 16384, -16384, 16384));
    pending_mats.push_back(make_matrix(1, 1, 1, 1, 1));
    pending_mats.push_back(make_matrix(-1, -1, -1, -1, -1));
    pending_mats.push_back(make_matrix(-1, 0, 1, 0, -1));
    // beyond unit range, full sample width
    pending_mats.push_back(make_matrix(32767, 32767, -32768, 32767, 32767));
    pending_mats.push_back(make_matrix(-32768, -32768, 32767, -32768, -32768));
    pending_mats.push_back(make_matrix(-32768, 0, -32768, 0, -32768));
    pending_mats.push_back(make_matrix(11585, 11585, -11585, 8192, 8192));
    // random: mostly true rotations, then raw entries, tiny vectors, full width
    for (int i = 0; i < N_RANDOM; i++) begin
      k = $urandom_range(99);
      if (k < 60)
        pending_mats.push_back(random_rotation());
      else if (k < 85)
        pending_mats.push_back(make_matrix(rand_signed(16384), rand_signed(16384),
                                           rand_signed(16384), rand_signed(16384),
                                           rand_signed(16384)));
      else if (k < 95)
        pending_mats.push_back(make_matrix(rand_signed(3), rand_signed(3), rand_signed(8),
                                           rand_signed(3), rand_signed(3)));
      else
        pending_mats.push_back(make_matrix($urandom(), $urandom(), $urandom(),
                                           $urandom(), $urandom()));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // let all stimulus go in, then drain the pipeline
    while (pending_mats.size() != 0 || start) @(posedge clk);
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("Sent %0d matrices: directed corners, half-turn and gimbal-lock cases,",
             n_sent);
    $display("random rotations, raw and tiny entries; %0d angle triples checked.",
             n_checked);
    if (n_fail == 0) begin
      $display("** rotation_matrix_to_euler_zyx_core: PASSED **");
    end else begin
      $display("** rotation_matrix_to_euler_zyx_core: FAILED **");
    end
    $finish;
  end

endmodule
